### rtl/poc_pkg.sv
// Package for the pixel-over compositing pipeline: pixel and side-band types,
// Q8.16 constants and the exact divide-by-255 helper.
// No dependencies.
package poc_pkg;

  localparam int ByteW = 8;
  localparam int AlphaW = 24;   // Q8.16 effective alpha
  localparam int QuoW = 17;     // blend factor, 0 .. 1.0 in Q1.16
  localparam int WorkW = 32;

  localparam logic [QuoW-1:0] OneQ16 = 17'h10000;

  // floor(s / 255) for s < 2^17: (s * Div255Mul) >> Div255Sh
  localparam logic [17:0] Div255Mul = 18'd131587;
  localparam int Div255Sh = 25;

  localparam logic CfgOpacity = 1'b0;
  localparam logic CfgMaskEn = 1'b1;

  typedef struct packed {
    logic [2:0][ByteW-1:0] src_c;
    logic [2:0][ByteW-1:0] dst_c;
    logic [ByteW-1:0]      dst_a;
  } pix_t;

  typedef struct packed {
    pix_t             pix;
    logic             part;
    logic [QuoW-1:0]  b_alt;
    logic [ByteW-1:0] alpha;
  } side_t;

  // Exact floor(x / 255) for any 32-bit x, using 2^16 = 255*257 + 1.
  function automatic logic [24:0] div255(input logic [WorkW-1:0] x);
    logic [15:0] h;
    logic [16:0] s;
    logic [34:0] p;
    logic [24:0] hh;
    h  = x[31:16];
    s  = {1'b0, h} + {1'b0, x[15:0]};
    p  = 35'(s) * 35'(Div255Mul);
    hh = {1'b0, h, 8'b0} + {9'b0, h};
    return hh + {15'b0, p[34:Div255Sh]};
  endfunction

endpackage

### rtl/poc_div.sv
// Pipelined restoring divider for the blend factor: one quotient bit per stage,
// side-band pixel data travels along. Depends on poc_pkg.
module poc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [poc_pkg::AlphaW-1:0]  in_num_i,
  input  logic [poc_pkg::AlphaW-1:0]  in_den_i,
  input  poc_pkg::side_t              in_side_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [poc_pkg::QuoW-1:0]    out_quo_o,
  output poc_pkg::side_t              out_side_o
);

  localparam int Stages = poc_pkg::QuoW;
  localparam int AW = poc_pkg::AlphaW;

  typedef struct packed {
    logic [AW-1:0]              rem;
    logic [AW-1:0]              den;
    logic [poc_pkg::QuoW-1:0]   quo;
    poc_pkg::side_t             side;
  } stage_t;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] vld_prev;
  logic [Stages:0]   rdy;
  stage_t            stg_q [Stages];
  stage_t            stg_d [Stages];

  assign vld_prev = {vld_q[Stages-2:0], in_valid_i};

  always_comb begin
    rdy[Stages] = out_ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    logic        ge0;
    logic [AW:0] r2;
    logic        ge;
    ge0 = in_num_i >= in_den_i;
    stg_d[0].den  = in_den_i;
    stg_d[0].side = in_side_i;
    stg_d[0].quo  = {{(poc_pkg::QuoW-1){1'b0}}, ge0};
    stg_d[0].rem  = ge0 ? (in_num_i - in_den_i) : in_num_i;
    for (int k = 1; k < Stages; k++) begin
      r2 = {stg_q[k-1].rem, 1'b0};
      ge = r2 >= {1'b0, stg_q[k-1].den};
      stg_d[k].den  = stg_q[k-1].den;
      stg_d[k].side = stg_q[k-1].side;
      stg_d[k].quo  = {stg_q[k-1].quo[poc_pkg::QuoW-2:0], ge};
      stg_d[k].rem  = ge ? AW'(r2 - {1'b0, stg_q[k-1].den}) : r2[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_prev[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Stages; k++) begin
      if (rdy[k] && vld_prev[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[Stages-1];
  assign out_quo_o   = stg_q[Stages-1].quo;
  assign out_side_o  = stg_q[Stages-1].side;

endmodule

### rtl/pixel_over_composite.sv
// Top level of the pixel-over compositing pipeline: config registers, alpha
// stages, blend divider (poc_div) and color mix. Depends on poc_pkg, poc_div.
//
//  port group  dir  beat contents (lowest bits first)
//  s_axis      in   src_color_1..3, src_opacity, dst_color_1..3, dst_opacity, mask_value
//  m_axis      out  out_color_1..3, out_opacity
//  cfg         in   0: opacity_level, 1: mask_enable
//
// One pixel per clock sustained while the output is not stalled; the pipeline
// has 6 alpha stages, 17 divider stages (one quotient bit each) and 2 mix stages.
// Reset clears all stage valid bits and loads opacity 255, mask enabled.
// Each stage holds its beat while the one after it is full and stalled, so
// empty stages keep filling while the output waits.
module pixel_over_composite (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // src_color_1, src_color_2, src_color_3,
                                      // src_opacity, dst_color_1, dst_color_2,
                                      // dst_color_3, dst_opacity, mask_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_color_1, out_color_2, out_color_3,
                                      // out_opacity
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int FrontStages = 6;
  localparam int BW = poc_pkg::ByteW;
  localparam int AW = poc_pkg::AlphaW;
  localparam int WW = poc_pkg::WorkW;
  localparam int QW = poc_pkg::QuoW;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_OPAQUE,
    KIND_CLEAR,
    KIND_PART
  } kind_e;

  typedef struct packed {
    poc_pkg::pix_t pix;
    logic [BW-1:0] mv;
    logic          msk;
    logic [WW-1:0] w;
    logic [AW-1:0] a;
    logic [QW-1:0] bop;
    kind_e         kind;
  } front_t;

  typedef struct packed {
    logic [2:0][AW-1:0] pd;
    logic [2:0][AW-1:0] ps;
    logic [BW-1:0]      alpha;
  } mix_t;

  // configuration
  logic [BW-1:0] opacity_q;
  logic          mask_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= 8'd255;
      mask_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        poc_pkg::CfgOpacity: opacity_q <= cfg_data_i;
        poc_pkg::CfgMaskEn:  mask_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // front alpha stages
  logic [FrontStages-1:0] vf_q;
  logic [FrontStages-1:0] vf_prev;
  logic [FrontStages:0]   rdy_f;
  front_t                 fr_q [FrontStages];
  front_t                 fr_d [FrontStages];
  logic                   div_in_ready;

  assign vf_prev = {vf_q[FrontStages-2:0], s_axis_tvalid};

  always_comb begin
    rdy_f[FrontStages] = div_in_ready;
    for (int k = FrontStages - 1; k >= 0; k--) begin
      rdy_f[k] = !vf_q[k] || rdy_f[k+1];
    end
  end

  always_comb begin
    logic [24:0] q1;
    logic [24:0] q3;
    logic [24:0] q4;
    logic [24:0] q5;
    logic [BW-1:0] da;

    fr_d[0] = '0;
    for (int i = 0; i < 3; i++) begin
      fr_d[0].pix.src_c[i] = s_axis_tdata[BW*i +: BW];
      fr_d[0].pix.dst_c[i] = s_axis_tdata[32 + BW*i +: BW];
    end
    fr_d[0].pix.dst_a = s_axis_tdata[63:56];
    fr_d[0].mv        = s_axis_tdata[71:64];
    fr_d[0].msk       = mask_en_q;
    fr_d[0].w         = WW'(16'(s_axis_tdata[31:24]) * 16'(opacity_q));

    // A0 = floor(S*O*65536/255)
    q1 = poc_pkg::div255({fr_q[0].w[15:0], 16'b0});
    fr_d[1]   = fr_q[0];
    fr_d[1].a = q1[AW-1:0];

    fr_d[2]   = fr_q[1];
    fr_d[2].w = fr_q[1].msk ? WW'(WW'(fr_q[1].a) * WW'(fr_q[1].mv)) : WW'(fr_q[1].a);

    q3 = poc_pkg::div255(fr_q[2].w);
    fr_d[3]   = fr_q[2];
    fr_d[3].a = fr_q[2].msk ? q3[AW-1:0] : fr_q[2].w[AW-1:0];

    da = fr_q[3].pix.dst_a;
    q4 = poc_pkg::div255(WW'(fr_q[3].a));
    fr_d[4]     = fr_q[3];
    fr_d[4].w   = WW'(WW'(8'd255 - da) * WW'(fr_q[3].a));
    fr_d[4].bop = q4[QW-1:0];
    if (fr_q[3].a == '0) begin
      fr_d[4].kind = KIND_ZERO;
    end else if (da == 8'd255) begin
      fr_d[4].kind = KIND_OPAQUE;
    end else if (da == 8'd0) begin
      fr_d[4].kind = KIND_CLEAR;
    end else begin
      fr_d[4].kind = KIND_PART;
    end

    // N = D*65536 + floor((255-D)*A/255), kept in w
    q5 = poc_pkg::div255(fr_q[4].w);
    fr_d[5]   = fr_q[4];
    fr_d[5].w = WW'({fr_q[4].pix.dst_a, 16'b0}) + WW'(q5[AW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      for (int k = 0; k < FrontStages; k++) begin
        if (rdy_f[k]) begin
          vf_q[k] <= vf_prev[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FrontStages; k++) begin
      if (rdy_f[k] && vf_prev[k]) begin
        fr_q[k] <= fr_d[k];
      end
    end
  end

  assign s_axis_tready = rdy_f[0];

  // divider entry
  poc_pkg::side_t div_side;
  logic [AW-1:0]  div_den;

  always_comb begin
    div_den       = fr_q[FrontStages-1].w[AW-1:0];
    div_side.pix  = fr_q[FrontStages-1].pix;
    div_side.part = fr_q[FrontStages-1].kind == KIND_PART;
    case (fr_q[FrontStages-1].kind)
      KIND_ZERO: begin
        div_side.b_alt = '0;
        div_side.alpha = fr_q[FrontStages-1].pix.dst_a;
      end
      KIND_OPAQUE: begin
        div_side.b_alt = fr_q[FrontStages-1].bop;
        div_side.alpha = 8'd255;
      end
      KIND_CLEAR: begin
        div_side.b_alt = poc_pkg::OneQ16;
        div_side.alpha = fr_q[FrontStages-1].a[AW-1:16];
      end
      default: begin
        div_side.b_alt = '0;
        div_side.alpha = div_den[AW-1:16];
      end
    endcase
  end

  logic           div_out_valid;
  logic [QW-1:0]  div_quo;
  poc_pkg::side_t div_out_side;
  logic           rdy_m1;

  poc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vf_q[FrontStages-1]),
    .in_ready_o  (div_in_ready),
    .in_num_i    (fr_q[FrontStages-1].a),
    .in_den_i    (div_den),
    .in_side_i   (div_side),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_m1),
    .out_quo_o   (div_quo),
    .out_side_o  (div_out_side)
  );

  // color mix
  logic          vm1_q;
  mix_t          mix_q;
  mix_t          mix_d;
  logic          vout_q;
  logic [31:0]   out_q;
  logic [31:0]   out_d;
  logic          rdy_out;

  assign rdy_out = !vout_q || m_axis_tready;
  assign rdy_m1  = !vm1_q || rdy_out;

  always_comb begin
    logic [QW-1:0] b;
    logic [QW-1:0] nb;
    b  = div_out_side.part ? div_quo : div_out_side.b_alt;
    nb = poc_pkg::OneQ16 - b;
    for (int i = 0; i < 3; i++) begin
      mix_d.pd[i] = AW'(AW'(div_out_side.pix.dst_c[i]) * AW'(nb));
      mix_d.ps[i] = AW'(AW'(div_out_side.pix.src_c[i]) * AW'(b));
    end
    mix_d.alpha = div_out_side.alpha;
  end

  always_comb begin
    logic [AW:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = {1'b0, mix_q.pd[i]} + {1'b0, mix_q.ps[i]};
      out_d[BW*i +: BW] = sum[23:16];
    end
    out_d[31:24] = mix_q.alpha;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q  <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      if (rdy_m1) begin
        vm1_q <= div_out_valid;
      end
      if (rdy_out) begin
        vout_q <= vm1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m1 && div_out_valid) begin
      mix_q <= mix_d;
    end
    if (rdy_out && vm1_q) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = vout_q;
  assign m_axis_tdata  = out_q;

endmodule
